[hw/rtl/mmc_pkg.sv]
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared widths, MIDI codes, register indexes and types of the metronome
// click generator.
// ----------------------------------------------------------------------------
package mmc_pkg;

    // Field and datapath widths
    localparam int unsigned DELTA_W   = 24;
    localparam int unsigned LEN_W     = 28;
    localparam int unsigned BPB_W     = 6;
    localparam int unsigned DELAY_W   = 24;
    localparam int unsigned POS_W     = 30;  // signed tracker position
    localparam int unsigned POS_MAG_W = 29;  // magnitude of a position
    localparam int unsigned STEP_W    = 5;   // remainder unit step count
    localparam int unsigned SLOT_W    = 2;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;

    // Register indexes (paddr word address)
    localparam logic [1:0] REG_BEAT_LEN = 2'd0;
    localparam logic [1:0] REG_BPB      = 2'd1;
    localparam logic [1:0] REG_DELAY    = 2'd2;

    // Register reset values
    localparam logic [LEN_W-1:0]   BEAT_LEN_RST = 28'd500000;
    localparam logic [BPB_W-1:0]   BPB_RST      = 6'd4;
    localparam logic [DELAY_W-1:0] DELAY_RST    = 24'd0;

    // MIDI codes
    localparam logic [7:0] ST_NOTE_OFF = 8'h89;
    localparam logic [7:0] ST_NOTE_ON  = 8'h99;
    localparam logic [6:0] NOTE_HI     = 7'h38;
    localparam logic [6:0] NOTE_ACCENT = 7'h51;
    localparam logic [6:0] NOTE_LO     = 7'h32;
    localparam logic [6:0] NOTE_CLAVE  = 7'h25;
    localparam logic [6:0] VEL_FULL    = 7'h7F;

    // Lamp colors
    localparam logic [1:0] LAMP_DARK  = 2'd0;
    localparam logic [1:0] LAMP_RED   = 2'd1;
    localparam logic [1:0] LAMP_GREEN = 2'd2;

    // Beat seen by a tracker on one tick
    typedef enum logic [1:0] {
        BEAT_NONE   = 2'd0,
        BEAT_STRONG = 2'd1,
        BEAT_WEAK   = 2'd2
    } t_beat;

    // Result sequence produced for one tick
    typedef enum logic [1:0] {
        K_EMPTY  = 2'd0,
        K_STOP   = 2'd1,
        K_STRONG = 2'd2,
        K_WEAK   = 2'd3
    } t_kind;

    // One outgoing result, lamp excluded
    typedef struct packed {
        logic       event_valid;
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       last;
    } t_msg;

endpackage

[hw/rtl/mmc_rem_unit.sv]
// ----------------------------------------------------------------------------
// mmc_rem_unit
// Restoring remainder unit: one dividend bit per cycle, MSB first. The
// dividend arrives left-aligned; the step count says how many bits to take.
// ----------------------------------------------------------------------------
module mmc_rem_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mmc_pkg::POS_MAG_W-1:0]      i_dividend,
    input  logic [mmc_pkg::LEN_W-1:0]          i_divisor,
    input  logic [mmc_pkg::STEP_W-1:0]         i_steps,
    output logic                               o_done,
    output logic [mmc_pkg::LEN_W-1:0]          o_rem
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [mmc_pkg::STEP_W-1:0]        r_cnt, n_cnt;
    logic [mmc_pkg::POS_MAG_W-1:0]     r_d, n_d;
    logic [mmc_pkg::LEN_W-1:0]         r_r, n_r;
    logic [mmc_pkg::LEN_W-1:0]         r_v, n_v;
    logic [mmc_pkg::LEN_W:0]           trial;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_d    = r_d;
        n_r    = r_r;
        n_v    = r_v;
        trial  = {r_r, r_d[mmc_pkg::POS_MAG_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_steps;
            n_d    = i_dividend;
            n_r    = '0;
            n_v    = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_v}) begin
                n_r = mmc_pkg::LEN_W'(trial - {1'b0, r_v});
            end else begin
                n_r = trial[mmc_pkg::LEN_W-1:0];
            end
            n_d   = {r_d[mmc_pkg::POS_MAG_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == mmc_pkg::STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_d <= n_d;
        r_r <= n_r;
        r_v <= n_v;
    end

    assign o_done = r_done;
    assign o_rem  = r_r;

endmodule

[hw/rtl/mmc_msg_sel.sv]
// ----------------------------------------------------------------------------
// mmc_msg_sel
// Message table: maps a tick's result sequence and the slot within it to the
// MIDI bytes and the end-of-sequence flag.
// ----------------------------------------------------------------------------
module mmc_msg_sel (
    input  mmc_pkg::t_kind                 i_kind,
    input  logic [mmc_pkg::SLOT_W-1:0]     i_slot,
    output mmc_pkg::t_msg                  o_msg
);

    // Build a note message
    function automatic mmc_pkg::t_msg note_msg(input logic [7:0] st,
                                               input logic [6:0] nt,
                                               input logic       lst);
        mmc_pkg::t_msg m;
        m.event_valid = 1'b1;
        m.status      = st;
        m.note        = nt;
        m.velocity    = mmc_pkg::VEL_FULL;
        m.last        = lst;
        return m;
    endfunction

    always_comb begin
        o_msg      = '0;
        o_msg.last = 1'b1;
        case (i_kind)
            mmc_pkg::K_STOP: begin
                case (i_slot)
                    2'd0:    o_msg = note_msg(mmc_pkg::ST_NOTE_OFF, mmc_pkg::NOTE_CLAVE, 1'b0);
                    2'd1:    o_msg = note_msg(mmc_pkg::ST_NOTE_OFF, mmc_pkg::NOTE_ACCENT, 1'b0);
                    default: o_msg = note_msg(mmc_pkg::ST_NOTE_OFF, mmc_pkg::NOTE_HI, 1'b1);
                endcase
            end
            mmc_pkg::K_STRONG: begin
                case (i_slot)
                    2'd0:    o_msg = note_msg(mmc_pkg::ST_NOTE_OFF, mmc_pkg::NOTE_HI, 1'b0);
                    2'd1:    o_msg = note_msg(mmc_pkg::ST_NOTE_OFF, mmc_pkg::NOTE_ACCENT, 1'b0);
                    default: o_msg = note_msg(mmc_pkg::ST_NOTE_ON, mmc_pkg::NOTE_ACCENT, 1'b1);
                endcase
            end
            mmc_pkg::K_WEAK: begin
                case (i_slot)
                    2'd0:    o_msg = note_msg(mmc_pkg::ST_NOTE_OFF, mmc_pkg::NOTE_LO, 1'b0);
                    default: o_msg = note_msg(mmc_pkg::ST_NOTE_ON, mmc_pkg::NOTE_LO, 1'b1);
                endcase
            end
            default: begin
                o_msg      = '0;
                o_msg.last = 1'b1;
            end
        endcase
    end

endmodule

[hw/rtl/midi_metronome_click_generator.sv]
// ----------------------------------------------------------------------------
// midi_metronome_click_generator
// Free-running metronome: lamp and click beat trackers advanced by tick beats,
// MIDI click messages out, one shared remainder unit under a small sequencer.
//
// Channel   Direction  Handshake            Payload
// tick      in         i_valid / o_ready    i_delta_us, i_run
// result    out        o_valid / i_ready    o_event_valid, o_midi_status,
//                                           o_midi_note, o_midi_velocity,
//                                           o_lamp_color, o_last
// config    in         APB psel/penable     paddr, pwdata, prdata, pready
//
// A running tick adds the delta to each tracker in S_ADD; a tracker that fires
// also runs the bit-serial remainder unit in S_POSDIV and S_IDXDIV. S_LAMP then
// sets the lamp and the click kind before the results.
// A zero-delta or stopped tick goes straight to its results.
// Each result then holds as long as i_ready stays low.
// o_ready is high only while no tick is in work. Reset is synchronous, active
// low, and resets the configuration registers and trackers.
// ----------------------------------------------------------------------------
module midi_metronome_click_generator #(
    parameter int unsigned MAX_BEATS_PER_BAR = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mmc_pkg::DELTA_W-1:0]       i_delta_us,
    input  logic                              i_run,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_event_valid,
    output logic [7:0]                        o_midi_status,
    output logic [6:0]                        o_midi_note,
    output logic [6:0]                        o_midi_velocity,
    output logic [1:0]                        o_lamp_color,
    output logic                              o_last,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mmc_pkg::ADDR_W-1:0]        paddr,
    input  logic [mmc_pkg::DATA_W-1:0]        pwdata,
    output logic [mmc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int unsigned IDXW = $clog2(MAX_BEATS_PER_BAR);
    localparam int unsigned BW   = IDXW + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ADD    = 6'b000010,
        S_POSDIV = 6'b000100,
        S_IDXDIV = 6'b001000,
        S_LAMP   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    // Registers
    t_state                              r_state, n_state;
    logic [mmc_pkg::LEN_W-1:0]           r_len, n_len;
    logic [mmc_pkg::BPB_W-1:0]           r_bpb, n_bpb;
    logic [mmc_pkg::DELAY_W-1:0]         r_delay, n_delay;
    logic signed [mmc_pkg::POS_W-1:0]    r_lamp_pos, n_lamp_pos;
    logic [IDXW-1:0]                     r_lamp_idx, n_lamp_idx;
    logic                                r_lamp_first, n_lamp_first;
    logic signed [mmc_pkg::POS_W-1:0]    r_click_pos, n_click_pos;
    logic [IDXW-1:0]                     r_click_idx, n_click_idx;
    logic                                r_click_first, n_click_first;
    logic                                r_playing, n_playing;
    logic [1:0]                          r_lamp, n_lamp;
    mmc_pkg::t_kind                      r_kind, n_kind;
    logic [mmc_pkg::SLOT_W-1:0]          r_slot, n_slot;
    logic [mmc_pkg::DELTA_W-1:0]         r_delta, n_delta;
    logic                                r_sel, n_sel;
    logic                                r_neg, n_neg;
    mmc_pkg::t_beat                      r_lamp_ev, n_lamp_ev;
    mmc_pkg::t_beat                      r_click_ev, n_click_ev;

    // Combinational
    logic                                in_acc;
    logic                                cfg_we;
    logic [mmc_pkg::LEN_W-1:0]           len_eff;
    logic [BW-1:0]                       bpb_eff;
    logic signed [mmc_pkg::POS_W-1:0]    cur_pos;
    logic [IDXW-1:0]                     cur_idx;
    logic                                cur_first;
    logic signed [mmc_pkg::POS_W-1:0]    sum;
    logic [mmc_pkg::POS_W-1:0]           sum_abs;
    logic                                fire;
    logic signed [mmc_pkg::POS_W-1:0]    rem_pos;
    logic [BW-1:0]                       idx_inc;
    logic                                lamp_quarter;
    logic                                div_start;
    logic [mmc_pkg::POS_MAG_W-1:0]       div_dividend;
    logic [mmc_pkg::LEN_W-1:0]           div_divisor;
    logic [mmc_pkg::STEP_W-1:0]          div_steps;
    logic                                div_done;
    logic [mmc_pkg::LEN_W-1:0]           div_rem;
    mmc_pkg::t_msg                       msg;

    mmc_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    mmc_msg_sel u_msg (
        .i_kind (r_kind),
        .i_slot (r_slot),
        .o_msg  (msg)
    );

    assign in_acc = i_valid && o_ready;
    assign cfg_we = psel && penable && pwrite && pready;

    // Clamp beat length and beats per bar to usable values
    always_comb begin
        len_eff = (r_len == '0) ? mmc_pkg::LEN_W'(1) : r_len;
        if (r_bpb == '0) begin
            bpb_eff = BW'(1);
        end else if (7'(r_bpb) > 7'(MAX_BEATS_PER_BAR)) begin
            bpb_eff = BW'(MAX_BEATS_PER_BAR);
        end else begin
            bpb_eff = BW'(r_bpb);
        end
    end

    // Datapath of the tracker in work
    always_comb begin
        cur_pos   = r_sel ? r_click_pos : r_lamp_pos;
        cur_idx   = r_sel ? r_click_idx : r_lamp_idx;
        cur_first = r_sel ? r_click_first : r_lamp_first;
        sum       = cur_pos + $signed({{(mmc_pkg::POS_W - mmc_pkg::DELTA_W){1'b0}}, r_delta});
        sum_abs   = sum[mmc_pkg::POS_W-1] ? mmc_pkg::POS_W'(-sum) : sum;
        fire      = cur_first ||
                    (sum >= $signed({{(mmc_pkg::POS_W - mmc_pkg::LEN_W){1'b0}}, len_eff}));
        rem_pos   = $signed({{(mmc_pkg::POS_W - mmc_pkg::LEN_W){1'b0}}, div_rem});
        if (r_neg) begin
            rem_pos = -rem_pos;
        end
        idx_inc      = {1'b0, cur_idx} + BW'(1);
        lamp_quarter = !r_lamp_pos[mmc_pkg::POS_W-1] &&
                       ({r_lamp_pos[mmc_pkg::POS_MAG_W-1:0], 2'b00} >=
                        (mmc_pkg::POS_MAG_W + 2)'(len_eff));
    end

    // Sequencer and state update
    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_bpb         = r_bpb;
        n_delay       = r_delay;
        n_lamp_pos    = r_lamp_pos;
        n_lamp_idx    = r_lamp_idx;
        n_lamp_first  = r_lamp_first;
        n_click_pos   = r_click_pos;
        n_click_idx   = r_click_idx;
        n_click_first = r_click_first;
        n_playing     = r_playing;
        n_lamp        = r_lamp;
        n_kind        = r_kind;
        n_slot        = r_slot;
        n_delta       = r_delta;
        n_sel         = r_sel;
        n_neg         = r_neg;
        n_lamp_ev     = r_lamp_ev;
        n_click_ev    = r_click_ev;
        div_start     = 1'b0;
        div_dividend  = sum_abs[mmc_pkg::POS_MAG_W-1:0];
        div_divisor   = len_eff;
        div_steps     = mmc_pkg::STEP_W'(mmc_pkg::POS_MAG_W);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_slot = '0;
                    n_kind = mmc_pkg::K_EMPTY;
                    if (i_delta_us == '0) begin
                        n_state = S_EMIT;
                    end else if (!i_run) begin
                        // Stop: rewind both trackers and silence the clicks
                        if (r_playing) begin
                            n_lamp_pos    = -$signed({{(mmc_pkg::POS_W - mmc_pkg::DELAY_W){1'b0}},
                                                      r_delay});
                            n_lamp_idx    = '0;
                            n_lamp_first  = 1'b1;
                            n_click_pos   = '0;
                            n_click_idx   = '0;
                            n_click_first = 1'b1;
                            n_playing     = 1'b0;
                            n_lamp        = mmc_pkg::LAMP_DARK;
                            n_kind        = mmc_pkg::K_STOP;
                        end
                        n_state = S_EMIT;
                    end else begin
                        n_playing = 1'b1;
                        n_delta   = i_delta_us;
                        n_sel     = 1'b0;
                        n_state   = S_ADD;
                    end
                end
            end

            S_ADD: begin
                if (fire) begin
                    n_neg     = sum[mmc_pkg::POS_W-1];
                    div_start = 1'b1;
                    n_state   = S_POSDIV;
                end else begin
                    if (r_sel) begin
                        n_click_pos = sum;
                        n_click_ev  = mmc_pkg::BEAT_NONE;
                        n_state     = S_LAMP;
                    end else begin
                        n_lamp_pos = sum;
                        n_lamp_ev  = mmc_pkg::BEAT_NONE;
                        n_sel      = 1'b1;
                        n_state    = S_ADD;
                    end
                end
            end

            S_POSDIV: begin
                // Take the position remainder, then wrap the beat index
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = {idx_inc, {(mmc_pkg::POS_MAG_W - BW){1'b0}}};
                    div_divisor  = mmc_pkg::LEN_W'(bpb_eff);
                    div_steps    = mmc_pkg::STEP_W'(BW);
                    if (r_sel) begin
                        n_click_pos   = rem_pos;
                        n_click_first = 1'b0;
                        n_click_ev    = (cur_idx == '0) ? mmc_pkg::BEAT_STRONG
                                                        : mmc_pkg::BEAT_WEAK;
                    end else begin
                        n_lamp_pos   = rem_pos;
                        n_lamp_first = 1'b0;
                        n_lamp_ev    = (cur_idx == '0) ? mmc_pkg::BEAT_STRONG
                                                       : mmc_pkg::BEAT_WEAK;
                    end
                    n_state = S_IDXDIV;
                end
            end

            S_IDXDIV: begin
                if (div_done) begin
                    if (r_sel) begin
                        n_click_idx = div_rem[IDXW-1:0];
                        n_state     = S_LAMP;
                    end else begin
                        n_lamp_idx = div_rem[IDXW-1:0];
                        n_sel      = 1'b1;
                        n_state    = S_ADD;
                    end
                end
            end

            S_LAMP: begin
                // Light on a beat, go dark after a quarter beat
                case (r_lamp_ev)
                    mmc_pkg::BEAT_STRONG: n_lamp = mmc_pkg::LAMP_RED;
                    mmc_pkg::BEAT_WEAK:   n_lamp = mmc_pkg::LAMP_GREEN;
                    default: begin
                        if (lamp_quarter) begin
                            n_lamp = mmc_pkg::LAMP_DARK;
                        end
                    end
                endcase
                case (r_click_ev)
                    mmc_pkg::BEAT_STRONG: n_kind = mmc_pkg::K_STRONG;
                    mmc_pkg::BEAT_WEAK:   n_kind = mmc_pkg::K_WEAK;
                    default:              n_kind = mmc_pkg::K_EMPTY;
                endcase
                n_slot  = '0;
                n_state = S_EMIT;
            end

            S_EMIT: begin
                // Advance through the results of this tick
                if (i_ready) begin
                    if (msg.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register writes; the lamp delay reloads the lamp tracker while stopped
        if (cfg_we) begin
            case (paddr[3:2])
                mmc_pkg::REG_BEAT_LEN: n_len = pwdata[mmc_pkg::LEN_W-1:0];
                mmc_pkg::REG_BPB:      n_bpb = pwdata[mmc_pkg::BPB_W-1:0];
                mmc_pkg::REG_DELAY: begin
                    n_delay = pwdata[mmc_pkg::DELAY_W-1:0];
                    if (!r_playing) begin
                        n_lamp_pos = -$signed({{(mmc_pkg::POS_W - mmc_pkg::DELAY_W){1'b0}},
                                               pwdata[mmc_pkg::DELAY_W-1:0]});
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_len         <= mmc_pkg::BEAT_LEN_RST;
            r_bpb         <= mmc_pkg::BPB_RST;
            r_delay       <= mmc_pkg::DELAY_RST;
            r_lamp_pos    <= -$signed({{(mmc_pkg::POS_W - mmc_pkg::DELAY_W){1'b0}},
                                       mmc_pkg::DELAY_RST});
            r_lamp_idx    <= '0;
            r_lamp_first  <= 1'b1;
            r_click_pos   <= '0;
            r_click_idx   <= '0;
            r_click_first <= 1'b1;
            r_playing     <= 1'b0;
            r_lamp        <= mmc_pkg::LAMP_DARK;
            r_kind        <= mmc_pkg::K_EMPTY;
            r_slot        <= '0;
        end else begin
            r_state       <= n_state;
            r_len         <= n_len;
            r_bpb         <= n_bpb;
            r_delay       <= n_delay;
            r_lamp_pos    <= n_lamp_pos;
            r_lamp_idx    <= n_lamp_idx;
            r_lamp_first  <= n_lamp_first;
            r_click_pos   <= n_click_pos;
            r_click_idx   <= n_click_idx;
            r_click_first <= n_click_first;
            r_playing     <= n_playing;
            r_lamp        <= n_lamp;
            r_kind        <= n_kind;
            r_slot        <= n_slot;
        end
        r_delta    <= n_delta;
        r_sel      <= n_sel;
        r_neg      <= n_neg;
        r_lamp_ev  <= n_lamp_ev;
        r_click_ev <= n_click_ev;
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            mmc_pkg::REG_BEAT_LEN: prdata = mmc_pkg::DATA_W'(r_len);
            mmc_pkg::REG_BPB:      prdata = mmc_pkg::DATA_W'(r_bpb);
            mmc_pkg::REG_DELAY:    prdata = mmc_pkg::DATA_W'(r_delay);
            default:               prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_EMIT);
    assign o_event_valid   = msg.event_valid;
    assign o_midi_status   = msg.status;
    assign o_midi_note     = msg.note;
    assign o_midi_velocity = msg.velocity;
    assign o_lamp_color    = r_lamp;
    assign o_last          = msg.last;

`ifndef ASSERT_OFF
    // A tick is never taken while results are still going out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("tick accepted while results pending");

    // The final beat of a tick ends the result burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (!o_valid && o_ready))
        else $error("results continue after last");

    // The lamp never shows an undefined color
    a_lamp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_lamp_color != 2'd3)
        else $error("undefined lamp color");

    // Stopping always rewinds the click tracker
    a_stop_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_kind == mmc_pkg::K_STOP) |-> (r_click_first && !r_playing))
        else $error("stop without tracker rewind");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the metronome click generator. Tick beats are
// offered on the valid/ready input, and every result beat is compared
// field by field with a predictor that tracks the lamp and click beat
// positions, bar index, run state and lamp color. A short directed table is
// followed by random ticks under six register settings with varying
// backpressure, one long receiver hold-off, and register read-back over APB.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 10;
    localparam int MAX_BEATS       = 32;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int N_PHASES        = 6;
    localparam int N_DIRECTED      = 18;
    localparam int MAX_REPORTS     = 10;
    localparam int TRK_LAMP        = 0;
    localparam int TRK_CLICK       = 1;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [mmc_pkg::DELTA_W-1:0] DELTA_MAX = '1;

    // One result beat as seen on the output channel
    typedef struct packed {
        logic       ev;
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] vel;
        logic [1:0] lamp;
        logic       last;
    } t_click_res;

    // Directed tick; known rows carry a hand-written expectation
    typedef struct packed {
        logic [mmc_pkg::DELTA_W-1:0] delta;
        logic                        run;
        logic                        known;
        mmc_pkg::t_kind              kind;
        logic [1:0]                  lamp;
    } t_tick_row;

    // Register setting of one random phase
    typedef struct packed {
        logic [31:0] len;
        logic [31:0] bpb;
        logic [31:0] delay;
        logic        poke;
    } t_cfg_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [mmc_pkg::DELTA_W-1:0] i_delta_us;
    logic                        i_run;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic                        o_event_valid;
    logic [7:0]                  o_midi_status;
    logic [6:0]                  o_midi_note;
    logic [6:0]                  o_midi_velocity;
    logic [1:0]                  o_lamp_color;
    logic                        o_last;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [mmc_pkg::ADDR_W-1:0]  paddr;
    logic [mmc_pkg::DATA_W-1:0]  pwdata;
    logic [mmc_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // Predictor state and register copy
    logic [mmc_pkg::LEN_W-1:0]   cfg_len;
    logic [mmc_pkg::BPB_W-1:0]   cfg_bpb;
    logic [mmc_pkg::DELAY_W-1:0] cfg_delay;
    longint                      trk_pos [2];
    int unsigned                 trk_idx [2];
    bit                          trk_first [2];
    bit                          playing;
    logic [1:0]                  lamp_now;

    t_click_res         pending_clicks [$];
    t_click_res         seen;
    t_click_res         want;
    t_tick_row          directed_ticks [N_DIRECTED];
    t_cfg_row           phase_cfg [N_PHASES];

    int                 err_count = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    bit                 offering = 1'b0;
    bit                 recv_hold = 1'b0;
    bit                 hold_go = 1'b0;

    midi_metronome_click_generator #(
        .MAX_BEATS_PER_BAR (MAX_BEATS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_delta_us      (i_delta_us),
        .i_run           (i_run),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_valid   (o_event_valid),
        .o_midi_status   (o_midi_status),
        .o_midi_note     (o_midi_note),
        .o_midi_velocity (o_midi_velocity),
        .o_lamp_color    (o_lamp_color),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint beat_len_eff();
        if (cfg_len == '0) begin
            return 1;
        end
        return longint'(cfg_len);
    endfunction

    function automatic int unsigned bar_len_eff();
        if (cfg_bpb == '0) begin
            return 1;
        end
        if (cfg_bpb > MAX_BEATS) begin
            return MAX_BEATS;
        end
        return 32'(cfg_bpb);
    endfunction

    function automatic void reload_trackers();
        trk_pos[TRK_LAMP]    = -longint'(cfg_delay);
        trk_pos[TRK_CLICK]   = 0;
        trk_idx[TRK_LAMP]    = 0;
        trk_idx[TRK_CLICK]   = 0;
        trk_first[TRK_LAMP]  = 1'b1;
        trk_first[TRK_CLICK] = 1'b1;
    endfunction

    // Add the elapsed time; fire on the first tick or on reaching the length
    function automatic mmc_pkg::t_beat advance_tracker(int t,
                                                       logic [mmc_pkg::DELTA_W-1:0] delta);
        longint span;
        bit     on_downbeat;
        span = beat_len_eff();
        trk_pos[t] = trk_pos[t] + longint'(delta);
        if (trk_pos[t] >= span || trk_first[t]) begin
            trk_first[t] = 1'b0;
            trk_pos[t]   = trk_pos[t] % span;
            on_downbeat  = (trk_idx[t] == 0);
            trk_idx[t]   = (trk_idx[t] + 1) % bar_len_eff();
            return on_downbeat ? mmc_pkg::BEAT_STRONG : mmc_pkg::BEAT_WEAK;
        end
        return mmc_pkg::BEAT_NONE;
    endfunction

    // Advance the metronome by one tick and name the result sequence
    function automatic mmc_pkg::t_kind metronome_step(logic [mmc_pkg::DELTA_W-1:0] delta,
                                                      logic run);
        mmc_pkg::t_beat lamp_beat;
        mmc_pkg::t_beat click_beat;
        if (delta == '0) begin
            return mmc_pkg::K_EMPTY;
        end
        if (!run) begin
            if (playing) begin
                reload_trackers();
                playing  = 1'b0;
                lamp_now = mmc_pkg::LAMP_DARK;
                return mmc_pkg::K_STOP;
            end
            return mmc_pkg::K_EMPTY;
        end
        playing    = 1'b1;
        lamp_beat  = advance_tracker(TRK_LAMP, delta);
        click_beat = advance_tracker(TRK_CLICK, delta);
        if (lamp_beat == mmc_pkg::BEAT_STRONG) begin
            lamp_now = mmc_pkg::LAMP_RED;
        end else if (lamp_beat == mmc_pkg::BEAT_WEAK) begin
            lamp_now = mmc_pkg::LAMP_GREEN;
        end else if (trk_pos[TRK_LAMP] >= 0 &&
                     trk_pos[TRK_LAMP] * 4 >= beat_len_eff()) begin
            lamp_now = mmc_pkg::LAMP_DARK;
        end
        case (click_beat)
            mmc_pkg::BEAT_STRONG: return mmc_pkg::K_STRONG;
            mmc_pkg::BEAT_WEAK:   return mmc_pkg::K_WEAK;
            default:              return mmc_pkg::K_EMPTY;
        endcase
    endfunction

    // Expand a result sequence into the beats expected on the output
    function automatic void queue_clicks(mmc_pkg::t_kind kind, logic [1:0] lamp);
        logic [7:0] st [3];
        logic [6:0] nt [3];
        int         cnt;
        t_click_res res;
        st  = '{mmc_pkg::ST_NOTE_OFF, mmc_pkg::ST_NOTE_OFF, mmc_pkg::ST_NOTE_OFF};
        nt  = '{mmc_pkg::NOTE_HI, mmc_pkg::NOTE_HI, mmc_pkg::NOTE_HI};
        cnt = 0;
        case (kind)
            mmc_pkg::K_STOP: begin
                cnt = 3;
                nt  = '{mmc_pkg::NOTE_CLAVE, mmc_pkg::NOTE_ACCENT, mmc_pkg::NOTE_HI};
            end
            mmc_pkg::K_STRONG: begin
                cnt = 3;
                st  = '{mmc_pkg::ST_NOTE_OFF, mmc_pkg::ST_NOTE_OFF, mmc_pkg::ST_NOTE_ON};
                nt  = '{mmc_pkg::NOTE_HI, mmc_pkg::NOTE_ACCENT, mmc_pkg::NOTE_ACCENT};
            end
            mmc_pkg::K_WEAK: begin
                cnt = 2;
                st  = '{mmc_pkg::ST_NOTE_OFF, mmc_pkg::ST_NOTE_ON, mmc_pkg::ST_NOTE_OFF};
                nt  = '{mmc_pkg::NOTE_LO, mmc_pkg::NOTE_LO, mmc_pkg::NOTE_LO};
            end
            default: cnt = 0;
        endcase
        if (cnt == 0) begin
            res = '{1'b0, 8'd0, 7'd0, 7'd0, lamp, 1'b1};
            pending_clicks = {pending_clicks, res};
        end
        for (int i = 0; i < cnt; i++) begin
            res.ev     = 1'b1;
            res.status = st[i];
            res.note   = nt[i];
            res.vel    = mmc_pkg::VEL_FULL;
            res.lamp   = lamp;
            res.last   = (i == cnt - 1);
            pending_clicks = {pending_clicks, res};
        end
    endfunction

    function automatic logic [31:0] reg_mask(logic [1:0] idx);
        case (idx)
            mmc_pkg::REG_BEAT_LEN:
                return {{(32 - mmc_pkg::LEN_W){1'b0}}, {mmc_pkg::LEN_W{1'b1}}};
            mmc_pkg::REG_BPB:
                return {{(32 - mmc_pkg::BPB_W){1'b0}}, {mmc_pkg::BPB_W{1'b1}}};
            mmc_pkg::REG_DELAY:
                return {{(32 - mmc_pkg::DELAY_W){1'b0}}, {mmc_pkg::DELAY_W{1'b1}}};
            default:
                return 32'd0;
        endcase
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write one register, mirror it in the predictor, read it back if it is a used index
    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        apb_access(1'b1, idx, value, readback);
        case (idx)
            mmc_pkg::REG_BEAT_LEN: cfg_len = value[mmc_pkg::LEN_W-1:0];
            mmc_pkg::REG_BPB:      cfg_bpb = value[mmc_pkg::BPB_W-1:0];
            mmc_pkg::REG_DELAY: begin
                cfg_delay = value[mmc_pkg::DELAY_W-1:0];
                if (!playing) begin
                    trk_pos[TRK_LAMP] = -longint'(cfg_delay);
                end
            end
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            apb_access(1'b0, idx, 32'd0, readback);
            if ((readback & reg_mask(idx)) !== (value & reg_mask(idx))) begin
                flag_error($sformatf("register %0d read-back: expected %h, got %h",
                                     idx, value & reg_mask(idx), readback));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tick sender
    // ------------------------------------------------------------------
    task automatic set_idle(int mode);
        case (mode)
            0: begin
                send_idle_pct = 30;
                recv_idle_pct = 80;
            end
            1: begin
                send_idle_pct = 80;
                recv_idle_pct = 30;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one tick beat and hold it until accepted
    task automatic offer_tick(input logic [mmc_pkg::DELTA_W-1:0] delta, input logic run);
        if ($urandom_range(99) < send_idle_pct) begin
            if (offering) begin
                i_valid <= 1'b0;
            end
            offering = 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid    <= 1'b1;
        i_delta_us <= delta;
        i_run      <= run;
        offering   = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pick_random_tick(output logic [mmc_pkg::DELTA_W-1:0] delta,
                                    output logic run);
        int unsigned roll;
        longint      span;
        roll = $urandom_range(99);
        span = beat_len_eff();
        if (span > longint'(DELTA_MAX)) begin
            span = longint'(DELTA_MAX);
        end
        run = 1'b1;
        if (roll < 5) begin
            delta = '0;
            run   = 1'($urandom_range(1));
        end else if (roll < 9) begin
            delta = mmc_pkg::DELTA_W'($urandom_range(DELTA_MAX, 1));
            run   = 1'b0;
        end else if (roll < 11) begin
            delta = DELTA_MAX;
        end else if (roll < 25) begin
            delta = mmc_pkg::DELTA_W'($urandom_range(DELTA_MAX, 1));
        end else if (roll < 40) begin
            delta = mmc_pkg::DELTA_W'($urandom_range(32'(span), 1));
        end else begin
            delta = mmc_pkg::DELTA_W'($urandom_range(32'(span / 3 + 1), 1));
        end
    endtask

    // Stop offering, then wait until every expected beat has come back
    task automatic drain_results();
        if (offering) begin
            i_valid <= 1'b0;
        end
        offering = 1'b0;
        while (pending_clicks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result receiver, hold-off and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold off the receiver long enough for the block to back up
    initial begin
        @(posedge hold_go);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen = '{o_event_valid, o_midi_status, o_midi_note, o_midi_velocity,
                     o_lamp_color, o_last};
            if (pending_clicks.size() == 0) begin
                flag_error($sformatf("unexpected result: ev=%0d st=%h note=%h lamp=%0d",
                                     seen.ev, seen.status, seen.note, seen.lamp));
            end else begin
                want = pending_clicks.pop_front();
                if (seen !== want) begin
                    flag_error($sformatf({"result mismatch: expected ev=%0d st=%h note=%h ",
                                          "vel=%h lamp=%0d last=%0d, got ev=%0d st=%h ",
                                          "note=%h vel=%h lamp=%0d last=%0d"},
                                         want.ev, want.status, want.note, want.vel,
                                         want.lamp, want.last, seen.ev, seen.status,
                                         seen.note, seen.vel, seen.lamp, seen.last));
                end
            end
        end
    end

    // Hard limit on run time
    initial begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [mmc_pkg::DELTA_W-1:0] delta;
        logic                        run;
        mmc_pkg::t_kind              kind;
        t_cfg_row                    c;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_delta_us = '0;
        i_run      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        directed_ticks = '{
            // zero delta after reset
            '{24'd0,      1'b0, 1'b1, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // stopped while stopped
            '{DELTA_MAX,  1'b0, 1'b1, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // first tick fires strong
            '{24'd1,      1'b1, 1'b1, mmc_pkg::K_STRONG, mmc_pkg::LAMP_RED},
            // no beat, lamp held
            '{24'd100000, 1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // quarter passed, lamp off
            '{24'd25000,  1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // reaches length exactly
            '{24'd374999, 1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // zero delta while playing
            '{24'd0,      1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // zero delta is not a stop
            '{24'd0,      1'b0, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // largest step
            '{DELTA_MAX,  1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // stop after playing
            '{24'd1,      1'b0, 1'b1, mmc_pkg::K_STOP,   mmc_pkg::LAMP_DARK},
            // still stopped
            '{24'd5,      1'b0, 1'b1, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // restart, first tick
            '{24'd500000, 1'b1, 1'b1, mmc_pkg::K_STRONG, mmc_pkg::LAMP_RED},
            '{24'd500000, 1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            '{24'd500000, 1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            '{24'd500000, 1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // one short of a beat
            '{24'd499999, 1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // bar wraps to strong
            '{24'd1,      1'b1, 1'b0, mmc_pkg::K_EMPTY,  mmc_pkg::LAMP_DARK},
            // stop with top bit set
            '{24'h800000, 1'b0, 1'b1, mmc_pkg::K_STOP,   mmc_pkg::LAMP_DARK}
        };

        phase_cfg = '{
            '{32'd1200,       32'd3,  32'd250,      1'b0},
            '{32'd0,          32'd1,  32'd0,        1'b0},  // zero length acts as one
            '{32'hFFFF_FFFF,  32'd32, 32'hFFFF_FFFF, 1'b0},  // widest settings
            '{32'd5000,       32'd63, 32'd7000,     1'b0},  // written while playing
            '{32'd777,        32'd0,  32'd100,      1'b1},  // zero beats per bar
            '{32'd2600,       32'd7,  32'd1300,     1'b0}
        };

        // Predictor matches the register and tracker reset values
        cfg_len   = mmc_pkg::BEAT_LEN_RST;
        cfg_bpb   = mmc_pkg::BPB_RST;
        cfg_delay = mmc_pkg::DELAY_RST;
        playing   = 1'b0;
        lamp_now  = mmc_pkg::LAMP_DARK;
        reload_trackers();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks under reset settings
        set_idle(0);
        foreach (directed_ticks[i]) begin
            offer_tick(directed_ticks[i].delta, directed_ticks[i].run);
            kind = metronome_step(directed_ticks[i].delta, directed_ticks[i].run);
            if (directed_ticks[i].known) begin
                queue_clicks(directed_ticks[i].kind, directed_ticks[i].lamp);
            end else begin
                queue_clicks(kind, lamp_now);
            end
        end
        drain_results();

        // Random ticks, one register setting per phase
        for (int p = 0; p < N_PHASES; p++) begin
            c = phase_cfg[p];
            set_idle(p / 2);
            program_register(mmc_pkg::REG_BEAT_LEN, c.len);
            program_register(mmc_pkg::REG_BPB, c.bpb);
            program_register(mmc_pkg::REG_DELAY, c.delay);
            if (c.poke) begin
                program_register(REG_UNUSED, 32'hFFFF_FFFF);
            end
            @(posedge i_clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 4 && n == 20) begin
                    hold_go = 1'b1;
                end
                pick_random_tick(delta, run);
                offer_tick(delta, run);
                kind = metronome_step(delta, run);
                queue_clicks(kind, lamp_now);
            end
            // leave the next phase either running or stopped
            run = (p == 2);
            offer_tick(24'd1, run);
            kind = metronome_step(24'd1, run);
            queue_clicks(kind, lamp_now);
            drain_results();
        end

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
